[design/kcr_pkg.sv]
// Package with shared types and codes of the keyed counter registry.
`timescale 1ns / 1ps
`default_nettype none
package kcr_pkg;
   localparam int KEY_W = 64;
   localparam int VAL_W = 64;
   localparam int GEN_W = 32;

   typedef enum logic [2:0] {
      FUNC_SEED    = 3'd0,
      FUNC_PUBLISH = 3'd1,
      FUNC_QUERY   = 3'd2,
      FUNC_REMOVE  = 3'd3,
      FUNC_CLEAR   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_STALE = 2'd1,
      ST_FULL  = 2'd2,
      ST_ERROR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SEARCH = 2'd1,
      S_UPDATE = 2'd2,
      S_RESP   = 2'd3
   } state_type;

   typedef struct packed {
      logic [2:0]       func;
      logic [KEY_W-1:0] table_key;
      logic [VAL_W-1:0] counter_value;
      logic [VAL_W-1:0] durable_value;
      logic [GEN_W-1:0] expected_generation;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] next_value_out;
      logic [GEN_W-1:0] generation_out;
      logic             checkpoint_flag;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic update;
   } cmd_type;
endpackage
`default_nettype wire

[design/kcr_if.sv]
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface kcr_req_if;
   import kcr_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface kcr_rsp_if;
   import kcr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/keyed_counter_registry.sv]
// Top level of the keyed counter registry.
// Usage: requests arrive on the req channel (valid/ready), one transaction
// per operation: func, table_key, counter_value, durable_value and
// expected_generation. Each request yields exactly one response on the rsp
// channel carrying status, next_value_out, generation_out and
// checkpoint_flag.
// Sequence: the request register loads at the accepting edge, the search
// state then compares the key against all slots in parallel and registers
// the match results, and the update state performs the read-modify-write of
// the chosen slot and registers the response, which the response state
// presents; the controller steps through the idle, search, update and
// response states for each request.
// The block holds one request at a time; while a response waits for
// rsp_ready, req_ready stays low and the response holds steady.
// Reset (synchronous, active high) frees all slots, zeroes keys, values and
// generations, and clears the generation counter and pending flag at once.
`timescale 1ns / 1ps
`default_nettype none
module keyed_counter_registry #(
   parameter int NUM_SLOTS = 16
) (
   input wire logic clock,
   input wire logic reset,
   kcr_req_if.sink   req_if,
   kcr_rsp_if.source rsp_if
);
   import kcr_pkg::*;
   cmd_type cmd;

   kcr_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req_if.valid), .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
      .cmd
   );

   kcr_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
      .clock, .reset, .cmd,
      .req_payload(req_if.payload),
      .rsp_payload(rsp_if.payload)
   );
endmodule
`default_nettype wire

[design/kcr_ctrl.sv]
// Controller state machine sequencing capture, search, update and response.
`timescale 1ns / 1ps
`default_nettype none
module kcr_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output kcr_pkg::cmd_type     cmd
);
   import kcr_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SEARCH;
         S_SEARCH: state_in = S_UPDATE;
         S_UPDATE: state_in = S_RESP;
         S_RESP:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      rsp_valid   = (state_ff == S_RESP);
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.search  = (state_ff == S_SEARCH);
      cmd.update  = (state_ff == S_UPDATE);
   end
endmodule
`default_nettype wire

[design/kcr_datapath.sv]
// Slot table, parallel key match and read-modify-write of one entry.
`timescale 1ns / 1ps
`default_nettype none
module kcr_datapath #(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kcr_pkg::cmd_type cmd,
   input  wire kcr_pkg::req_type req_payload,
   output kcr_pkg::rsp_type      rsp_payload
);
   import kcr_pkg::*;
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [NUM_SLOTS-1:0] active_ff;
   logic [KEY_W-1:0]     key_ff [NUM_SLOTS];
   logic [VAL_W-1:0]     next_ff [NUM_SLOTS];
   logic [VAL_W-1:0]     dur_ff [NUM_SLOTS];
   logic [GEN_W-1:0]     gen_ff [NUM_SLOTS];
   logic [GEN_W-1:0]     gctr_ff;
   logic                 pend_ff;
   req_type              req_ff;
   rsp_type              rsp_ff;

   // Search results, registered between the search and update cycles.
   logic             live_hit_ff, tomb_hit_ff, free_hit_ff;
   logic [IDX_W-1:0] live_idx_ff, tomb_idx_ff, free_idx_ff;
   logic             live_hit_in, tomb_hit_in, free_hit_in;
   logic [IDX_W-1:0] live_idx_in, tomb_idx_in, free_idx_in;

   always_comb begin
      live_hit_in = 1'b0; tomb_hit_in = 1'b0; free_hit_in = 1'b0;
      live_idx_in = '0; tomb_idx_in = '0; free_idx_in = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (active_ff[i] && key_ff[i] == req_ff.table_key) begin
            live_hit_in = 1'b1; live_idx_in = IDX_W'(i);
         end
         if (!active_ff[i] && key_ff[i] == req_ff.table_key && gen_ff[i] != '0) begin
            tomb_hit_in = 1'b1; tomb_idx_in = IDX_W'(i);
         end
         if (!active_ff[i]) begin
            free_hit_in = 1'b1; free_idx_in = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
      if (cmd.search) begin
         live_hit_ff <= live_hit_in; tomb_hit_ff <= tomb_hit_in;
         free_hit_ff <= free_hit_in; live_idx_ff <= live_idx_in;
         tomb_idx_ff <= tomb_idx_in; free_idx_ff <= free_idx_in;
      end
   end

   // Update cycle: decide the outcome and the single slot write.
   logic [VAL_W-1:0] ln, ld;
   logic [GEN_W-1:0] lg, tg;
   logic             key_zero, cv_zero;
   rsp_type          rsp_in;
   logic             pend_in, wr_en, wr_act, gctr_inc;
   logic [IDX_W-1:0] wr_idx;
   logic [VAL_W-1:0] wr_next, wr_dur;

   always_comb begin
      ln = next_ff[live_idx_ff];
      ld = dur_ff[live_idx_ff];
      lg = gen_ff[live_idx_ff];
      tg = gen_ff[tomb_idx_ff];
      key_zero = (req_ff.table_key == '0);
      cv_zero  = (req_ff.counter_value == '0);
      rsp_in.status = ST_ERROR;
      rsp_in.next_value_out = '0;
      rsp_in.generation_out = '0;
      pend_in = pend_ff;
      wr_en = 1'b0; wr_act = 1'b1; gctr_inc = 1'b0;
      wr_idx = live_idx_ff; wr_next = ln; wr_dur = ld;
      case (req_ff.func)
         FUNC_SEED, FUNC_PUBLISH: begin
            if (!key_zero && !cv_zero) begin
               if (live_hit_ff) begin
                  rsp_in.status = ST_OK;
                  wr_en = 1'b1;
                  if (req_ff.counter_value > ln) wr_next = req_ff.counter_value;
                  if (req_ff.func == FUNC_SEED) begin
                     rsp_in.next_value_out = wr_next;
                  end else begin
                     if (req_ff.durable_value > ld) wr_dur = req_ff.durable_value;
                     if (req_ff.counter_value > ln || req_ff.durable_value > ld)
                        pend_in = 1'b1;
                  end
               end else if (tomb_hit_ff) begin
                  rsp_in.status = ST_STALE;
               end else if (!free_hit_ff) begin
                  rsp_in.status = ST_FULL;
               end else if (gctr_ff != '1) begin
                  rsp_in.status = ST_OK;
                  wr_en = 1'b1; gctr_inc = 1'b1;
                  wr_idx = free_idx_ff;
                  wr_next = req_ff.counter_value;
                  if (req_ff.func == FUNC_SEED) begin
                     wr_dur = '0;
                     rsp_in.next_value_out = req_ff.counter_value;
                  end else begin
                     wr_dur = req_ff.durable_value;
                     pend_in = 1'b1;
                  end
               end
            end
         end
         FUNC_QUERY: begin
            if (!key_zero) begin
               if (live_hit_ff) begin
                  rsp_in.status = ST_OK;
                  rsp_in.generation_out = lg;
               end else begin
                  rsp_in.status = ST_STALE;
               end
            end
         end
         FUNC_REMOVE: begin
            if (!key_zero && req_ff.expected_generation != '0) begin
               rsp_in.status = ST_STALE;
               if (live_hit_ff) begin
                  if (lg == req_ff.expected_generation) begin
                     rsp_in.status = ST_OK;
                     pend_in = 1'b1;
                     wr_en = 1'b1; wr_act = 1'b0;
                     wr_next = '0; wr_dur = '0;
                  end
               end else if (tomb_hit_ff && tg == req_ff.expected_generation) begin
                  rsp_in.status = ST_OK;
               end
            end
         end
         FUNC_CLEAR: begin
            pend_in = 1'b0;
            rsp_in.status = ST_OK;
         end
         default: ;
      endcase
      rsp_in.checkpoint_flag = pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         gctr_ff   <= '0;
         pend_ff   <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            key_ff[i] <= '0; next_ff[i] <= '0; dur_ff[i] <= '0; gen_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         pend_ff <= pend_in;
         if (gctr_inc) gctr_ff <= gctr_ff + 1'b1;
         if (wr_en) begin
            active_ff[wr_idx] <= wr_act;
            next_ff[wr_idx]   <= wr_next;
            dur_ff[wr_idx]    <= wr_dur;
            if (gctr_inc) begin
               key_ff[wr_idx] <= req_ff.table_key;
               gen_ff[wr_idx] <= gctr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

[design/kcr_checker.sv]
// Port-level checker for the keyed counter registry, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kcr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [31:0] rsp_gen
);
   import kcr_pkg::*;
   a_resp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##3 rsp_valid) else $error("missing response");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken during response");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_gen_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gen != '0 |-> rsp_status == ST_OK)
      else $error("generation on failed op");
endmodule

bind keyed_counter_registry kcr_checker u_kcr_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_if.valid), .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
   .rsp_status(rsp_if.payload.status),
   .rsp_gen(rsp_if.payload.generation_out)
);
`default_nettype wire

[verif/keyed_counter_registry_tb.sv]
// Self-checking testbench for the keyed counter registry.
`timescale 1ns / 1ps
`default_nettype none
module keyed_counter_registry_tb;
   import kcr_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kcr_req_if req_if ();
   kcr_rsp_if rsp_if ();

   keyed_counter_registry #(.NUM_SLOTS(NSLOT)) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the registry table.
   logic             tbl_active [NSLOT];
   logic [KEY_W-1:0] tbl_key [NSLOT];
   logic [VAL_W-1:0] tbl_next [NSLOT];
   logic [VAL_W-1:0] tbl_durable [NSLOT];
   logic [GEN_W-1:0] tbl_gen [NSLOT];
   logic [GEN_W-1:0] gen_count;
   logic             pending;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      calm = 1'b0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   logic [KEY_W-1:0] key_pool [8];

   function automatic int find_live(logic [KEY_W-1:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_active[i] && tbl_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int find_tomb(logic [KEY_W-1:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (!tbl_active[i] && tbl_key[i] == k && tbl_gen[i] != 0) return i;
      return -1;
   endfunction

   function automatic status_type create_entry(logic [KEY_W-1:0] k,
         logic [VAL_W-1:0] nv, logic [VAL_W-1:0] dv);
      int s;
      s = -1;
      if (find_tomb(k) >= 0) return ST_STALE;
      for (int i = NSLOT - 1; i >= 0; i--)
         if (!tbl_active[i]) s = i;
      if (s < 0) return ST_FULL;
      if (gen_count == '1) return ST_ERROR;
      gen_count = gen_count + 32'd1;
      tbl_gen[s] = gen_count;
      tbl_key[s] = k;
      tbl_next[s] = nv;
      tbl_durable[s] = dv;
      tbl_active[s] = 1'b1;
      return ST_OK;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type    o;
      status_type st;
      int         s;
      o = '0;
      st = ST_ERROR;
      case (r.func)
         FUNC_SEED: if (r.table_key != 0 && r.counter_value != 0) begin
            s = find_live(r.table_key);
            if (s < 0) begin
               st = create_entry(r.table_key, r.counter_value, '0);
               if (st == ST_OK) o.next_value_out = r.counter_value;
            end else begin
               if (r.counter_value > tbl_next[s]) tbl_next[s] = r.counter_value;
               o.next_value_out = tbl_next[s];
               st = ST_OK;
            end
         end
         FUNC_PUBLISH: if (r.table_key != 0 && r.counter_value != 0) begin
            s = find_live(r.table_key);
            if (s < 0) begin
               st = create_entry(r.table_key, r.counter_value, r.durable_value);
               if (st == ST_OK) pending = 1'b1;
            end else begin
               if (r.counter_value > tbl_next[s]) begin
                  tbl_next[s] = r.counter_value;
                  pending = 1'b1;
               end
               if (r.durable_value > tbl_durable[s]) begin
                  tbl_durable[s] = r.durable_value;
                  pending = 1'b1;
               end
               st = ST_OK;
            end
         end
         FUNC_QUERY: if (r.table_key != 0) begin
            s = find_live(r.table_key);
            if (s < 0) st = ST_STALE;
            else begin
               o.generation_out = tbl_gen[s];
               st = ST_OK;
            end
         end
         FUNC_REMOVE: if (r.table_key != 0 && r.expected_generation != 0) begin
            s = find_live(r.table_key);
            if (s < 0) s = find_tomb(r.table_key);
            if (s < 0 || tbl_gen[s] != r.expected_generation) st = ST_STALE;
            else begin
               if (tbl_active[s]) begin
                  pending = 1'b1;
                  tbl_active[s] = 1'b0;
                  tbl_next[s] = '0;
                  tbl_durable[s] = '0;
               end
               st = ST_OK;
            end
         end
         FUNC_CLEAR: begin
            pending = 1'b0;
            st = ST_OK;
         end
         default: st = ST_ERROR;
      endcase
      o.status = st;
      o.checkpoint_flag = pending;
      return o;
   endfunction

   function automatic req_type make_req(logic [2:0] f, logic [KEY_W-1:0] k,
         logic [VAL_W-1:0] cv, logic [VAL_W-1:0] dv, logic [GEN_W-1:0] eg);
      req_type r;
      r.func = f;
      r.table_key = k;
      r.counter_value = cv;
      r.durable_value = dv;
      r.expected_generation = eg;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Values are mostly small so that monotonic updates both rise and hold.
   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 5))
         0: return rand64();
         1: return 64'('1) - 64'($urandom_range(0, 3));
         2: return 64'd0;
         default: return 64'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Driver: presents queued requests, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid && req_if.ready)
            expected_rsps.push_back(apply_request(req_if.payload));
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_if.payload <= pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 11);
         end else
            req_if.valid <= 1'b0;
      end
   end

   // Monitor: checks each response against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 64'd1, 64'd0);
            end else begin
               rsp_type want;
               want = expected_rsps.pop_front();
               if (rsp_if.payload.status !== want.status)
                  report_mismatch("status", rsp_if.payload.status, want.status);
               if (rsp_if.payload.next_value_out !== want.next_value_out)
                  report_mismatch("next_value_out", rsp_if.payload.next_value_out,
                     want.next_value_out);
               if (rsp_if.payload.generation_out !== want.generation_out)
                  report_mismatch("generation_out", rsp_if.payload.generation_out,
                     want.generation_out);
               if (rsp_if.payload.checkpoint_flag !== want.checkpoint_flag)
                  report_mismatch("checkpoint_flag", rsp_if.payload.checkpoint_flag,
                     want.checkpoint_flag);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) rsp_gap <= $urandom_range(1, 11);
         end
      end
   end

   // Watchdog: counts cycles without any transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("keyed_counter_registry verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [2:0]       f;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < NSLOT; i++) begin
         tbl_active[i] = 1'b0;
         tbl_key[i] = '0;
         tbl_next[i] = '0;
         tbl_durable[i] = '0;
         tbl_gen[i] = '0;
      end
      gen_count = '0;
      pending = 1'b0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      for (int i = 0; i < 8; i++) key_pool[i] = (i == 0) ? '1 : rand64() | 64'd1;

      // Directed: extremes, every function, tombstones and error codes.
      pending_reqs.push_back(make_req(FUNC_QUERY, 64'd5, '0, '0, '0));
      pending_reqs.push_back(make_req(FUNC_SEED, '0, 64'd3, '0, '0));
      pending_reqs.push_back(make_req(FUNC_SEED, 64'd5, '0, '0, '0));
      pending_reqs.push_back(make_req(FUNC_SEED, 64'd5, 64'd10, '1, '1));
      pending_reqs.push_back(make_req(FUNC_SEED, 64'd5, 64'd4, '0, '0));
      pending_reqs.push_back(make_req(FUNC_SEED, '1, '1, '0, '0));
      pending_reqs.push_back(make_req(FUNC_PUBLISH, 64'd5, 64'd3, 64'd2, '0));
      pending_reqs.push_back(make_req(FUNC_PUBLISH, 64'd5, 64'd3, 64'd1, '0));
      pending_reqs.push_back(make_req(FUNC_CLEAR, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(FUNC_PUBLISH, 64'd5, 64'd3, 64'd1, '0));
      pending_reqs.push_back(make_req(FUNC_PUBLISH, 64'd7, '1, '1, '0));
      pending_reqs.push_back(make_req(FUNC_QUERY, 64'd7, '0, '0, '0));
      pending_reqs.push_back(make_req(FUNC_QUERY, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(FUNC_REMOVE, 64'd5, '0, '0, '0));
      pending_reqs.push_back(make_req(FUNC_REMOVE, 64'd5, '0, '0, 32'd2));
      pending_reqs.push_back(make_req(FUNC_REMOVE, 64'd5, '0, '0, 32'd1));
      pending_reqs.push_back(make_req(FUNC_REMOVE, 64'd5, '0, '0, 32'd1));
      pending_reqs.push_back(make_req(FUNC_SEED, 64'd5, 64'd9, '0, '0));
      pending_reqs.push_back(make_req(FUNC_PUBLISH, 64'd5, 64'd9, '0, '0));
      pending_reqs.push_back(make_req(FUNC_REMOVE, '1, '0, '0, '1));
      pending_reqs.push_back(make_req(3'd5, 64'd1, 64'd1, '0, '0));
      pending_reqs.push_back(make_req(3'd6, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(3'd7, 64'd1, 64'd1, '0, 32'd1));
      // Fill the table so that full is reached and a tombstone slot is reused.
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(make_req(FUNC_SEED, 64'h100 + i, 64'd1, '0, '0));
      pending_reqs.push_back(make_req(FUNC_REMOVE, 64'h100, '0, '0, 32'd4));
      pending_reqs.push_back(make_req(FUNC_SEED, 64'h200, 64'd2, '0, '0));

      // Random: mostly operations on a small key pool, some noise.
      for (int n = 0; n < 408; n++) begin
         f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
         case ($urandom_range(0, 9))
            0: k = '0;
            1: k = rand64();
            2, 3: k = 64'h100 + 64'($urandom_range(0, 16));
            default: k = key_pool[$urandom_range(0, 7)];
         endcase
         pending_reqs.push_back(make_req(f, k, rand_value(), rand_value(),
            ($urandom_range(0, 9) == 0) ? {$urandom()} : 32'($urandom_range(0, 30))));
         if (n == 380) pending_reqs.push_back(make_req(FUNC_CLEAR, '0, '0, '0, '0));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() >= 60) @(posedge clock);
      calm = 1'b1;
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("keyed_counter_registry verification clean");
      else
         $display("keyed_counter_registry verification failed");
      $finish;
   end
endmodule
`default_nettype wire
